// ===== design/ihex_pkg.sv =====
// Shared types, constants and functions of the Intel HEX record encoder.
// Self-contained; used by every module of the encoder.
package ihex_pkg;

  // Record geometry.
  localparam int unsigned RecLen  = 16;
  localparam int unsigned PosW    = $clog2(RecLen);
  localparam logic [PosW-1:0] RecLast = PosW'(RecLen - 1);
  localparam logic [7:0] RecLenByte = 8'(RecLen);

  // Job queue between the front and the back.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Input item kinds.
  localparam logic KindData = 1'b0;
  localparam logic KindEof  = 1'b1;

  // Character positions within one data line, in sending order.
  localparam logic [3:0] PosColon = 4'd0;
  localparam logic [3:0] PosLenHi = 4'd1;
  localparam logic [3:0] PosLenLo = 4'd2;
  localparam logic [3:0] PosAddr3 = 4'd3;
  localparam logic [3:0] PosAddr2 = 4'd4;
  localparam logic [3:0] PosAddr1 = 4'd5;
  localparam logic [3:0] PosAddr0 = 4'd6;
  localparam logic [3:0] PosTypHi = 4'd7;
  localparam logic [3:0] PosTypLo = 4'd8;
  localparam logic [3:0] PosDatHi = 4'd9;
  localparam logic [3:0] PosDatLo = 4'd10;
  localparam logic [3:0] PosChkHi = 4'd11;
  localparam logic [3:0] PosChkLo = 4'd12;
  localparam logic [3:0] PosCr    = 4'd13;
  localparam logic [3:0] PosLf    = 4'd14;
  // The end-of-file line is 13 characters, positions 0 to 12.
  localparam logic [3:0] PosEofLast = 4'd12;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChF     = 8'h46;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // One job per accepted item, classified by the front.
  typedef struct packed {
    logic        is_eof;
    logic        has_header;
    logic        has_trailer;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  checksum;
  } ihex_job_t;

  // Upper-case ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_ascii(input logic [3:0] v);
    hex_ascii = (v > 4'd9) ? (8'h37 + {4'd0, v}) : (8'h30 + {4'd0, v});
  endfunction

  // Characters of the line ":00000001FF" CR LF.
  function automatic logic [7:0] eof_char(input logic [3:0] pos);
    case (pos)
      4'd0:          eof_char = ChColon;
      4'd8:          eof_char = ChOne;
      4'd9, 4'd10:   eof_char = ChF;
      4'd11:         eof_char = ChCr;
      4'd12:         eof_char = ChLf;
      default:       eof_char = ChZero;
    endcase
  endfunction

endpackage

// ===== design/intel_hex_record_encoder_top.sv =====
// Top level of the Intel HEX data record encoder.
// Depends on ihex_pkg, ihex_front, ihex_fifo and ihex_back.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o | kind_i, data_byte_i, record_address_i
//   out     | out_valid_o/out_ready_i | text_char_o, last_char_o
//
// The output sends one character per cycle while out_ready_i holds and a job
// waits; an item has 2 characters for a middle byte, 11 for the first byte of a
// record, 6 for the last one, and 13 for end of file. That output register
// is the rate limit; 16 bytes of a record make 45 characters.
// Reset (rst_ni low, asynchronous) empties the job queue, clears the record
// position and checksum, and drops any character waiting at the output.
// The front keeps accepting items while the two-entry queue has room, so a
// stalled output only stops the input once the queue is full.
module intel_hex_record_encoder_top import ihex_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] record_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  text_char_o,
  output logic        last_char_o
);

  ihex_job_t job;
  ihex_job_t head;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  // An item is taken whenever the queue has room for its job.
  assign in_ready_o = !full;
  assign push       = in_valid_i && !full;

  // The front classifies the item and updates position and checksum.
  ihex_front u_front (
    .clk_i,
    .rst_ni,
    .push_i          (push),
    .kind_i,
    .data_byte_i,
    .record_address_i,
    .job_o           (job)
  );

  ihex_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (job),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  // The back retires the head job once its last character is registered.
  ihex_back u_back (
    .clk_i,
    .rst_ni,
    .head_i       (head),
    .head_valid_i (!empty),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .text_char_o,
    .last_char_o
  );

endmodule

// ===== design/ihex_front.sv =====
// Front of the encoder: accepts items, tracks record position and checksum,
// and turns each item into a job. Depends on ihex_pkg.
module ihex_front import ihex_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] record_address_i,
  output ihex_job_t   job_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      sum_base;
  logic [7:0]      sum_new;
  logic            first;
  logic            tail;

  always_comb begin
    first    = (pos_q == '0);
    tail     = (pos_q == RecLast);
    sum_base = first ? (RecLenByte + record_address_i[15:8] + record_address_i[7:0])
                     : sum_q;
    sum_new  = sum_base + data_byte_i;

    job_o.is_eof      = (kind_i == KindEof);
    job_o.has_header  = first;
    job_o.has_trailer = tail;
    job_o.address     = record_address_i;
    job_o.data        = data_byte_i;
    job_o.checksum    = 8'h00 - sum_new;

    pos_d = pos_q;
    sum_d = sum_q;
    if (push_i) begin
      if (kind_i == KindEof || tail) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
        sum_d = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

endmodule

// ===== design/ihex_fifo.sv =====
// Short first-word-fall-through job queue between front and back.
// Depends on ihex_pkg.
module ihex_fifo import ihex_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ihex_job_t push_data_i,
  input  logic      pop_i,
  output ihex_job_t head_o,
  output logic      full_o,
  output logic      empty_o
);

  ihex_job_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]    cnt_q;

  function automatic logic [FifoPtrW-1:0] ptr_inc(input logic [FifoPtrW-1:0] p);
    ptr_inc = (p == FifoPtrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/ihex_back.sv =====
// Back of the encoder: walks the head job one character per cycle, while the
// output is free or taken, into an output register. Depends on ihex_pkg.
module ihex_back import ihex_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ihex_job_t  head_i,
  input  logic       head_valid_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] text_char_o,
  output logic       last_char_o
);

  logic       started_q;
  logic [3:0] idx_q;
  logic [3:0] pos;
  logic       is_last;
  logic       load;
  logic [7:0] ch;
  logic       valid_q;
  logic [7:0] char_q;
  logic       last_q;

  always_comb begin
    if (started_q) begin
      pos = idx_q;
    end else if (head_i.is_eof || head_i.has_header) begin
      pos = PosColon;
    end else begin
      pos = PosDatHi;
    end

    if (head_i.is_eof) begin
      is_last = (pos == PosEofLast);
    end else if (head_i.has_trailer) begin
      is_last = (pos == PosLf);
    end else begin
      is_last = (pos == PosDatLo);
    end

    unique case (pos)
      PosColon: ch = ChColon;
      PosLenHi: ch = hex_ascii(RecLenByte[7:4]);
      PosLenLo: ch = hex_ascii(RecLenByte[3:0]);
      PosAddr3: ch = hex_ascii(head_i.address[15:12]);
      PosAddr2: ch = hex_ascii(head_i.address[11:8]);
      PosAddr1: ch = hex_ascii(head_i.address[7:4]);
      PosAddr0: ch = hex_ascii(head_i.address[3:0]);
      PosTypHi, PosTypLo: ch = ChZero;
      PosDatHi: ch = hex_ascii(head_i.data[7:4]);
      PosDatLo: ch = hex_ascii(head_i.data[3:0]);
      PosChkHi: ch = hex_ascii(head_i.checksum[7:4]);
      PosChkLo: ch = hex_ascii(head_i.checksum[3:0]);
      PosCr:    ch = ChCr;
      PosLf:    ch = ChLf;
      default:  ch = ChZero;
    endcase
    if (head_i.is_eof) begin
      ch = eof_char(pos);
    end

    load  = head_valid_i && (!valid_q || out_ready_i);
    pop_o = load && is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      idx_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (load) begin
        started_q <= !is_last;
        idx_q     <= pos + 4'd1;
        valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= ch;
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule
